// ===== hw/rtl/ccfh_pkg.sv =====
// Package for the circle collision first-hit unit: field widths, the entry
// record of one table slot, compare-unit control records and the controller states.
// Depends on nothing.
`default_nettype none

package ccfh_pkg;

	// Field widths fixed by the item format.
	localparam int unsigned POS_W     = 16;
	localparam int unsigned RAD_W     = 12;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned DEF_ENTRIES = 64;

	// Item kinds carried on the mode port.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// One table slot as held in a cell.
	typedef struct packed {
		logic                     present;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic [RAD_W-1:0]         r;
	} entry_t;

	// Control that enters the compare unit with each slot.
	typedef struct packed {
		logic valid;
		logic last;
		logic present;
	} cmp_req_t;

	// Control that leaves the compare unit.
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} cmp_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccfh_cell.sv =====
// One cell of the slot ring: holds a single table entry, takes a direct write
// when idle and hands its entry to its neighbor while a query rotates the ring.
// Depends on ccfh_pkg.
`default_nettype none

module ccfh_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire ccfh_pkg::entry_t wr_entry,
	input  wire logic            shift_en,
	input  wire ccfh_pkg::entry_t nxt,
	output ccfh_pkg::entry_t     cur
);

	logic                               present_q;
	logic signed [ccfh_pkg::POS_W-1:0]  x_q;
	logic signed [ccfh_pkg::POS_W-1:0]  y_q;
	logic [ccfh_pkg::RAD_W-1:0]         r_q;

	// The present flag is control state and clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
		end else if (wr_en) begin
			present_q <= wr_entry.present;
		end else if (shift_en) begin
			present_q <= nxt.present;
		end
	end

	// Position and radius carry no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q <= wr_entry.x;
			y_q <= wr_entry.y;
			r_q <= wr_entry.r;
		end else if (shift_en) begin
			x_q <= nxt.x;
			y_q <= nxt.y;
			r_q <= nxt.r;
		end
	end

	assign cur = {present_q, x_q, y_q, r_q};

endmodule

`default_nettype wire

// ===== hw/rtl/ccfh_cmp.sv =====
// Three-stage circle overlap compare: differences and radius sum, squares,
// then the distance sum against the squared radius sum.
// Depends on ccfh_pkg.
`default_nettype none

module ccfh_cmp #(
	parameter int unsigned IW = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ccfh_pkg::cmp_req_t                  req,
	input  wire logic [IW-1:0]                       req_idx,
	input  wire logic signed [ccfh_pkg::POS_W-1:0]   tx,
	input  wire logic signed [ccfh_pkg::POS_W-1:0]   ty,
	input  wire logic [ccfh_pkg::RAD_W-1:0]          tr,
	input  wire ccfh_pkg::entry_t                    ent,
	output ccfh_pkg::cmp_rsp_t                       rsp,
	output logic [IW-1:0]                            rsp_idx
);

	localparam int unsigned DW  = ccfh_pkg::POS_W + 1;
	localparam int unsigned SW  = 2 * ccfh_pkg::POS_W;
	localparam int unsigned RSW = ccfh_pkg::RAD_W + 1;

	// Stage 1 registers.
	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic [RSW-1:0]        rs_s1;
	ccfh_pkg::cmp_req_t    ctl_s1;
	logic [IW-1:0]         idx_s1;

	// Stage 2 registers.
	logic [SW-1:0]         dx2_s2, dy2_s2;
	logic [2*RSW-1:0]      rs2_s2;
	ccfh_pkg::cmp_req_t    ctl_s2;
	logic [IW-1:0]         idx_s2;

	// Stage 3 registers.
	ccfh_pkg::cmp_rsp_t    rsp_s3;
	logic [IW-1:0]         idx_s3;

	logic signed [2*DW-1:0] dx_sq, dy_sq;
	logic [2*RSW-1:0]       rs_sq;
	logic [SW:0]            dist_sum;

	// Control flags of every stage, and the stage 3 hit compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			rsp_s3 <= '0;
		end else begin
			ctl_s1    <= req;
			ctl_s2    <= ctl_s1;
			rsp_s3.valid <= ctl_s2.valid;
			rsp_s3.last  <= ctl_s2.last;
			rsp_s3.hit   <= ctl_s2.valid & ctl_s2.present & (dist_sum <= (SW+1)'(rs2_s2));
		end
	end

	// Squares of the differences and of the radius sum. A difference magnitude
	// stays below 2^16, so its square fits in 32 unsigned bits.
	assign dx_sq    = dx_s1 * dx_s1;
	assign dy_sq    = dy_s1 * dy_s1;
	assign rs_sq    = rs_s1 * rs_s1;
	assign dist_sum = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	// Payload through the stages.
	always_ff @(posedge clk) begin
		dx_s1  <= {tx[ccfh_pkg::POS_W-1], tx} - {ent.x[ccfh_pkg::POS_W-1], ent.x};
		dy_s1  <= {ty[ccfh_pkg::POS_W-1], ty} - {ent.y[ccfh_pkg::POS_W-1], ent.y};
		rs_s1  <= {1'b0, tr} + {1'b0, ent.r};
		idx_s1 <= req_idx;
		dx2_s2 <= dx_sq[SW-1:0];
		dy2_s2 <= dy_sq[SW-1:0];
		rs2_s2 <= rs_sq;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
	end

	assign rsp     = rsp_s3;
	assign rsp_idx = idx_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/circle_collision_first_hit_unit.sv =====
// Top level of the circle collision first-hit unit: a ring of slot cells,
// the shared overlap compare and the query controller.
// Depends on ccfh_pkg, ccfh_cell and ccfh_cmp.
//
//  Channel  | Ports                                             | Beat taken when
//  ---------+---------------------------------------------------+-------------------
//  item in  | mode entry_index entry_active pos_x pos_y         | start high, busy low
//           | circle_radius                                     |
//  result   | hit hit_index                                     | done high
//
// A write beat is taken and the unit is ready again at once.
// A query rotates the ring of ENTRIES cells past the compare unit, one slot a
// cycle, then drains the three compare stages: busy stays high throughout and
// done rises with busy falling; the next beat can be taken at the edge that
// takes the result.
// Reset clears every present flag at once; positions and radii are not reset.
// The receiver cannot stall; the result shows for one cycle under done.
`default_nettype none

module circle_collision_first_hit_unit #(
	parameter int unsigned ENTRIES = ccfh_pkg::DEF_ENTRIES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                mode,
	input  wire logic [ccfh_pkg::IDX_W-1:0]          entry_index,
	input  wire logic                                entry_active,
	input  wire logic signed [ccfh_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [ccfh_pkg::POS_W-1:0]   pos_y,
	input  wire logic [ccfh_pkg::RAD_W-1:0]          circle_radius,
	output logic                                     done,
	output logic                                     hit,
	output logic [ccfh_pkg::IDX_W-1:0]               hit_index
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	ccfh_pkg::state_t state_q, state_nxt;

	logic [IW-1:0]                       cnt_q;
	logic                                found_q;
	logic [IW-1:0]                       found_idx_q;
	logic signed [ccfh_pkg::POS_W-1:0]   tx_q, ty_q;
	logic [ccfh_pkg::RAD_W-1:0]          tr_q;
	logic                                done_q, hit_q;
	logic [IW-1:0]                       hit_idx_q;

	logic               accept, wr_en, query_go, scanning, last_slot;
	ccfh_pkg::entry_t   wr_entry;
	ccfh_pkg::entry_t   cells [ENTRIES];
	ccfh_pkg::cmp_req_t req;
	ccfh_pkg::cmp_rsp_t rsp;
	logic [IW-1:0]      rsp_idx;
	logic [IW+ccfh_pkg::IDX_W-1:0] idx_wide;

	assign accept   = start & ~busy;
	assign wr_en    = accept & (mode == ccfh_pkg::MODE_WRITE);
	assign query_go = accept & (mode == ccfh_pkg::MODE_QUERY);
	assign last_slot = (cnt_q == IW'(ENTRIES - 1));

	assign wr_entry.present = entry_active;
	assign wr_entry.x       = pos_x;
	assign wr_entry.y       = pos_y;
	assign wr_entry.r       = circle_radius;

	// Ring of slot cells; cell 0 faces the compare unit and takes from cell 1.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ccfh_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en && (32'(entry_index) == i)),
			.wr_entry (wr_entry),
			.shift_en (scanning),
			.nxt      (cells[(i + 1) % ENTRIES]),
			.cur      (cells[i])
		);
	end

	// Next-state logic of the query controller.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ccfh_pkg::ST_IDLE: begin
				if (query_go) state_nxt = ccfh_pkg::ST_SCAN;
			end
			ccfh_pkg::ST_SCAN: begin
				if (last_slot) state_nxt = ccfh_pkg::ST_DRAIN;
			end
			ccfh_pkg::ST_DRAIN: begin
				if (rsp.valid && rsp.last) state_nxt = ccfh_pkg::ST_IDLE;
			end
			default: state_nxt = ccfh_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the query controller.
	always_comb begin
		busy     = 1'b1;
		scanning = 1'b0;
		case (state_q)
			ccfh_pkg::ST_IDLE:  busy = 1'b0;
			ccfh_pkg::ST_SCAN:  scanning = 1'b1;
			ccfh_pkg::ST_DRAIN: busy = 1'b1;
			default:            busy = 1'b0;
		endcase
	end

	// Slot handed to the compare unit this cycle.
	assign req.valid   = scanning;
	assign req.last    = scanning & last_slot;
	assign req.present = cells[0].present;

	ccfh_cmp #(.IW(IW)) u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.req_idx (cnt_q),
		.tx      (tx_q),
		.ty      (ty_q),
		.tr      (tr_q),
		.ent     (cells[0]),
		.rsp     (rsp),
		.rsp_idx (rsp_idx)
	);

	// Controller state, slot counter, first-hit tracking and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccfh_pkg::ST_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= rsp.valid & rsp.last;
			if (query_go) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (scanning) cnt_q <= cnt_q + 1'b1;
				if (rsp.valid && rsp.hit) found_q <= 1'b1;
			end
		end
	end

	// Test circle, first-hit index and result payload.
	always_ff @(posedge clk) begin
		if (query_go) begin
			tx_q <= pos_x;
			ty_q <= pos_y;
			tr_q <= circle_radius;
		end
		if (rsp.valid && rsp.hit && !found_q) found_idx_q <= rsp_idx;
		if (rsp.valid && rsp.last) begin
			hit_q     <= found_q | rsp.hit;
			hit_idx_q <= found_q ? found_idx_q : (rsp.hit ? rsp_idx : '0);
		end
	end

	assign idx_wide  = {{ccfh_pkg::IDX_W{1'b0}}, hit_idx_q};
	assign done      = done_q;
	assign hit       = hit_q;
	assign hit_index = idx_wide[ccfh_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

// ===== verif/circle_collision_first_hit_unit_test.sv =====
// Testbench for circle_collision_first_hit_unit: directed and random table writes and
// collision queries, checked against a scoreboard that keeps its own slot table.
// Depends on ccfh_pkg and the circle_collision_first_hit_unit RTL.

module circle_collision_first_hit_unit_test;
	import ccfh_pkg::*;

	localparam int SLOTS        = DEF_ENTRIES;
	localparam int RANDOM_BEATS = 1530;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE       = 80;
	localparam int MAX_REPORTS  = 10;

	// One input beat as it appears on the item ports.
	typedef struct packed {
		logic                    mode;
		logic [IDX_W-1:0]        index;
		logic                    active;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [RAD_W-1:0]        radius;
	} beat_t;

	// One query answer.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} hit_report_t;

	// Keeps a shadow of the slot table and the answers still owed by the block.
	class overlap_scoreboard;
		entry_t      slots[SLOTS];
		hit_report_t pending_hits[$];
		int          errors;
		int          writes;
		int          queries;
		int          hits_owed;

		function new();
			foreach (slots[i]) slots[i] = '0;
			errors = 0;
			writes = 0;
			queries = 0;
			hits_owed = 0;
		endfunction

		// Lowest present slot whose circle overlaps or touches the test circle.
		function hit_report_t first_overlap(beat_t q);
			hit_report_t rep;
			longint      dx;
			longint      dy;
			longint      rsum;
			rep = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slots[i].present) begin
					dx = longint'($signed(q.x)) - longint'($signed(slots[i].x));
					dy = longint'($signed(q.y)) - longint'($signed(slots[i].y));
					rsum = longint'(q.radius) + longint'(slots[i].r);
					if (dx * dx + dy * dy <= rsum * rsum) begin
						rep.hit = 1'b1;
						rep.index = i[IDX_W-1:0];
						break;
					end
				end
			end
			return rep;
		endfunction

		// A write updates the shadow table; a query owes one answer.
		function void note_beat(beat_t b);
			hit_report_t rep;
			if (b.mode == MODE_WRITE) begin
				slots[b.index].present = b.active;
				slots[b.index].x = b.x;
				slots[b.index].y = b.y;
				slots[b.index].r = b.radius;
				writes++;
			end else begin
				rep = first_overlap(b);
				pending_hits.push_back(rep);
				queries++;
				if (rep.hit)
					hits_owed++;
			end
		endfunction

		// Compares one strobed answer with the oldest one owed.
		function void check_result(logic hit, logic [IDX_W-1:0] index);
			hit_report_t want;
			if (pending_hits.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: hit %0d index %0d", hit, index);
				return;
			end
			want = pending_hits.pop_front();
			if (hit !== want.hit || index !== want.index) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result mismatch: expected hit %0d index %0d, got hit %0d index %0d",
						want.hit, want.index, hit, index);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    start         = 1'b0;
	logic                    mode          = MODE_WRITE;
	logic [IDX_W-1:0]        entry_index   = '0;
	logic                    entry_active  = 1'b0;
	logic signed [POS_W-1:0] pos_x         = '0;
	logic signed [POS_W-1:0] pos_y         = '0;
	logic [RAD_W-1:0]        circle_radius = '0;
	logic                    busy;
	logic                    done;
	logic                    hit;
	logic [IDX_W-1:0]        hit_index;

	overlap_scoreboard tracker;
	int                quiet_cycles = 0;
	int                drain_pauses = 0;

	circle_collision_first_hit_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.entry_index   (entry_index),
		.entry_active  (entry_active),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.circle_radius (circle_radius),
		.done          (done),
		.hit           (hit),
		.hit_index     (hit_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check answers before noting a new beat, since both can land on one edge.
	always @(posedge clk) begin : monitor
		beat_t seen;
		if (arst_n) begin
			if (done)
				tracker.check_result(hit, hit_index);
			if (start && !busy) begin
				seen = {mode, entry_index, entry_active, pos_x, pos_y, circle_radius};
				tracker.note_beat(seen);
			end
		end
	end

	// Ends the run if neither an input beat nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("circle_collision_first_hit_unit verification failed");
			$finish;
		end
	end

	// Presents one beat from the falling edge until the block takes it.
	task automatic drive_beat(input beat_t b);
		@(negedge clk);
		start <= 1'b1;
		mode <= b.mode;
		entry_index <= b.index;
		entry_active <= b.active;
		pos_x <= b.x;
		pos_y <= b.y;
		circle_radius <= b.radius;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic put(input logic m, input logic [IDX_W-1:0] idx, input logic act,
			input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
			input logic [RAD_W-1:0] r);
		beat_t b;
		b = {m, idx, act, x, y, r};
		drive_beat(b);
	endtask

	// Holds start low for a number of cycles with junk on the item ports.
	task automatic rest(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			mode <= 1'($urandom);
			entry_index <= IDX_W'($urandom);
			entry_active <= 1'($urandom);
			pos_x <= POS_W'($urandom);
			pos_y <= POS_W'($urandom);
			circle_radius <= RAD_W'($urandom);
		end
	endtask

	// Stops sending until every owed answer has come back.
	task automatic drain();
		rest(1);
		while (tracker.pending_hits.size() != 0)
			@(posedge clk);
		drain_pauses++;
	endtask

	// Coordinate either anywhere or in a crowded area around the origin.
	function automatic logic signed [POS_W-1:0] scatter(input logic wide);
		if (wide)
			return POS_W'($urandom);
		return POS_W'(int'($urandom_range(0, 4000)) - 2000);
	endfunction

	function automatic logic signed [POS_W-1:0] clip(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return POS_W'(v);
	endfunction

	// Random beat; many queries are aimed at the rim of a present slot so that
	// hits, touching circles and near misses all come up often.
	function automatic beat_t random_beat();
		beat_t b;
		int    pick;
		int    slot;
		int    rsum;
		int    dx;
		int    dy;
		b.mode = ($urandom_range(0, 99) < 45) ? MODE_WRITE : MODE_QUERY;
		b.index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 7))
			: IDX_W'($urandom_range(0, SLOTS - 1));
		b.active = ($urandom_range(0, 6) != 0);
		pick = $urandom_range(0, 9);
		b.x = scatter(pick < 3);
		b.y = scatter(pick < 3);
		b.radius = (pick < 2 || $urandom_range(0, 9) == 0) ? RAD_W'($urandom)
			: RAD_W'($urandom_range(0, 600));
		slot = $urandom_range(0, SLOTS - 1);
		if (b.mode == MODE_QUERY && pick >= 6 && tracker.slots[slot].present) begin
			rsum = int'(b.radius) + int'(tracker.slots[slot].r);
			dx = int'($urandom_range(0, rsum));
			dy = int'($floor($sqrt(real'(rsum * rsum - dx * dx))));
			dy = dy + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				dx = -dx;
			if ($urandom_range(0, 1))
				dy = -dy;
			b.x = clip(int'($signed(tracker.slots[slot].x)) + dx);
			b.y = clip(int'($signed(tracker.slots[slot].y)) + dy);
		end
		return b;
	endfunction

	initial begin
		int sent;
		int burst;
		tracker = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, coordinate extremes, touching, lowest index wins,
		// clearing writes, and query beats carrying junk index and active bits.
		put(MODE_QUERY, 6'd63, 1'b1, 16'sd0, 16'sd0, 12'hFFF);
		put(MODE_WRITE, 6'd0, 1'b1, 16'sh8000, 16'sh8000, 12'hFFF);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, 12'hFFF);
		put(MODE_QUERY, 6'd63, 1'b1, 16'sh8000, 16'sh8000, 12'h000);
		put(MODE_WRITE, 6'd63, 1'b1, 16'sh7FFF, 16'sh7FFF, 12'h000);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, 12'h000);
		put(MODE_WRITE, 6'd20, 1'b1, 16'sd0, 16'sd0, 12'd32);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sd48, 16'sd64, 12'd48);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sd48, 16'sd65, 12'd48);
		put(MODE_QUERY, 6'd0, 1'b0, -16'sd48, -16'sd64, 12'd48);
		put(MODE_WRITE, 6'd7, 1'b1, 16'sd16, 16'sd16, 12'd16);
		put(MODE_QUERY, 6'd20, 1'b1, 16'sd48, 16'sd64, 12'd48);
		put(MODE_WRITE, 6'd7, 1'b0, 16'sd16, 16'sd16, 12'd16);
		put(MODE_QUERY, 6'd7, 1'b1, 16'sd48, 16'sd64, 12'd48);
		put(MODE_WRITE, 6'd20, 1'b0, 16'sd0, 16'sd0, 12'd32);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sd0, 16'sd0, 12'hFFF);
		put(MODE_WRITE, 6'd1, 1'b1, 16'sh8000, 16'sh7FFF, 12'hFFF);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sh8000, 16'sh7FFF, 12'hFFF);
		put(MODE_WRITE, 6'd0, 1'b0, 16'sh8000, 16'sh8000, 12'hFFF);
		put(MODE_QUERY, 6'd0, 1'b0, 16'sh8000, 16'sh8000, 12'hFFF);
		drain();

		// Random bursts separated by no gap, short gaps or long gaps, with some drains.
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				drive_beat(random_beat());
				sent++;
			end
			case ($urandom_range(0, 19))
				0:       drain();
				1, 2:    rest($urandom_range(20, 90));
				3, 4, 5,
				6, 7:    ;
				default: rest($urandom_range(1, 6));
			endcase
		end

		rest(1);
		while (tracker.pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d table writes and %0d queries (%0d hits), %0d drain pauses",
			tracker.writes, tracker.queries, tracker.hits_owed, drain_pauses);
		if (tracker.errors == 0 && tracker.pending_hits.size() == 0) begin
			$display("circle_collision_first_hit_unit verification clean");
		end else begin
			$display("%0d failures", tracker.errors);
			$display("circle_collision_first_hit_unit verification failed");
		end
		$finish;
	end

endmodule
